@@ sv/cbam_pkg.sv @@
// ----------------------------------------------------------------------------
// cbam_pkg: shared types and constants of the cartridge bus address mapper
// Holds the cartridge map codes, the device space bases and the base
// selector that travels down the pipeline.
// ----------------------------------------------------------------------------
package cbam_pkg;

  localparam int unsigned DevAddrW = 25;
  localparam int unsigned OffsW    = 23;

  // Cartridge map codes as held in the configuration register
  typedef enum logic [2:0] {
    MODE_UNKNOWN = 3'd0,
    MODE_LOROM   = 3'd1,
    MODE_HIROM   = 3'd2,
    MODE_EXLOROM = 3'd3,
    MODE_EXHIROM = 3'd4,
    MODE_SA1     = 3'd5
  } mode_t;

  // Region base picked in the decode stage
  typedef enum logic [1:0] {
    BASE_ZERO = 2'd0,
    BASE_XROM = 2'd1,
    BASE_SRAM = 2'd2,
    BASE_WRAM = 2'd3
  } base_t;

  localparam logic [DevAddrW-1:0] XromBase = 25'h0400000;
  localparam logic [DevAddrW-1:0] SramBase = 25'h0E00000;
  localparam logic [DevAddrW-1:0] WramBase = 25'h0F50000;
  localparam logic [DevAddrW-1:0] MaxDevAddr = 25'h127FFFF;

  // Device space address of a region base
  function automatic logic [DevAddrW-1:0] base_value(input base_t sel);
    logic [DevAddrW-1:0] val;
    unique case (sel)
      BASE_XROM: val = XromBase;
      BASE_SRAM: val = SramBase;
      BASE_WRAM: val = WramBase;
      default:   val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ sv/cartridge_bus_address_mapper.sv @@
// ----------------------------------------------------------------------------
// cartridge_bus_address_mapper: console bus to flat device address translation
// Three-stage pipeline: region decode, base add, ROM range compare.
// ----------------------------------------------------------------------------
// Takes one 24-bit bus address per cycle while out_tready allows it and returns
// its flat device address: ROM below 0xE00000, save RAM from 0xE00000, work RAM
// from 0xF50000, 0 for unmapped addresses. Banks 0x7E-0x7F always map to work
// RAM; everything else follows the cartridge map in the configuration register
// (0 unknown, 1 LoROM, 2 HiROM, 3 ExLoROM, 4 ExHiROM, 5 SA-1, other codes map
// to 0). ExLoROM save RAM in banks 0xF0-0xFF lands above 0xFFFFFF, so the
// result is 25 bits wide. The pipeline sustains one transaction per cycle when
// the consumer is ready and holds its contents under back-pressure; the decode,
// add and compare register stages lie between input and result. Write the map
// register only while no transaction is in flight.
module cartridge_bus_address_mapper (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data,    // mapping_mode
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // [23:0] bus_address
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [24:0] device_address, [31:25] zero
  output logic [0:0]  out_tuser    // [0] result_is_rom
);
  import cbam_pkg::*;

  mode_t                mode_r;
  logic                 rdy1, rdy2, rdy3;
  logic                 v1_r, v2_r, v3_r;
  base_t                sel1_r, sel_nxt;
  logic [OffsW-1:0]     offs1_r, offs_nxt;
  logic [DevAddrW-1:0]  addr2_r, addr2_nxt;
  logic [DevAddrW-1:0]  addr3_r;
  logic                 rom3_r, rom_nxt;

  // Accept every configuration transaction
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_UNKNOWN;
    end else if (cfg_valid) begin
      mode_r <= mode_t'(cfg_data);
    end
  end

  // Advance a stage when it is empty or the next one moves
  assign rdy3      = !v3_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_tvalid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Stage 1: decode region into base selector and offset
  always_comb begin
    logic [23:0] a;
    a        = in_tdata;
    sel_nxt  = BASE_ZERO;
    offs_nxt = '0;
    if (a[23:17] == 7'h3F) begin
      sel_nxt  = BASE_WRAM;
      offs_nxt = {6'd0, a[16:0]};
    end else begin
      unique case (mode_r)
        MODE_LOROM: begin
          // upper half mirrors the lower half
          priority if (a[22:20] == 3'b111 && !a[15]) begin
            sel_nxt  = BASE_SRAM;
            offs_nxt = {4'd0, a[19:16], a[14:0]};
          end else if (a[15:13] == 3'b000) begin
            sel_nxt  = BASE_WRAM;
            offs_nxt = {10'd0, a[12:0]};
          end else if (!a[15]) begin
            sel_nxt  = BASE_ZERO;
            offs_nxt = '0;
          end else begin
            sel_nxt  = BASE_ZERO;
            offs_nxt = {1'b0, a[22:16], a[14:0]};
          end
        end
        MODE_HIROM: begin
          priority if (a[22:21] == 2'b01 && a[15:13] == 3'b011) begin
            sel_nxt  = BASE_SRAM;
            offs_nxt = {5'd0, a[20:16], a[12:0]};
          end else if (!a[22] && a[15:13] == 3'b000) begin
            sel_nxt  = BASE_WRAM;
            offs_nxt = {10'd0, a[12:0]};
          end else begin
            sel_nxt  = BASE_ZERO;
            offs_nxt = {1'b0, a[21:0]};
          end
        end
        MODE_EXLOROM: begin
          // banks 0xF0-0xFF keep the offset relative to bank 0x70
          priority if (a[23:20] == 4'hF && !a[15]) begin
            sel_nxt  = BASE_SRAM;
            offs_nxt = {1'b1, 3'd0, a[19:16], a[14:0]};
          end else if (a[15:13] == 3'b000) begin
            sel_nxt  = BASE_WRAM;
            offs_nxt = {10'd0, a[12:0]};
          end else if (!a[15]) begin
            sel_nxt  = BASE_ZERO;
            offs_nxt = '0;
          end else begin
            sel_nxt  = a[23] ? BASE_ZERO : BASE_XROM;
            offs_nxt = {1'b0, a[22:16], a[14:0]};
          end
        end
        MODE_EXHIROM: begin
          priority if (a[23:22] == 2'b11) begin
            sel_nxt  = BASE_ZERO;
            offs_nxt = {1'b0, a[21:0]};
          end else if (a[23] && a[15]) begin
            sel_nxt  = BASE_ZERO;
            offs_nxt = {1'b0, a[21:16], 1'b0, a[14:0]};
          end else if (a[23:22] == 2'b01) begin
            sel_nxt  = BASE_XROM;
            offs_nxt = {1'b0, a[21:0]};
          end else if (!a[23] && a[15]) begin
            sel_nxt  = BASE_XROM;
            offs_nxt = {1'b0, a[21:16], 1'b0, a[14:0]};
          end else if (a[23:21] == 3'b101 && a[14:13] == 2'b11) begin
            sel_nxt  = BASE_SRAM;
            offs_nxt = {5'd0, a[20:16], a[12:0]};
          end else if (a[15:13] == 3'b000) begin
            sel_nxt  = BASE_WRAM;
            offs_nxt = {10'd0, a[12:0]};
          end else begin
            sel_nxt  = BASE_ZERO;
            offs_nxt = '0;
          end
        end
        MODE_SA1: begin
          priority if (a[23:22] == 2'b11) begin
            sel_nxt  = BASE_ZERO;
            offs_nxt = {1'b0, a[21:0]};
          end else if (a[23] && a[15]) begin
            sel_nxt  = BASE_ZERO;
            offs_nxt = {1'b0, 1'b1, a[21:16], a[14:0]};
          end else if (!a[23] && a[22:16] >= 7'h50) begin
            sel_nxt  = BASE_ZERO;
            offs_nxt = '0;
          end else if (!a[23] && a[22:16] >= 7'h44) begin
            sel_nxt  = BASE_SRAM;
            offs_nxt = {10'd0, a[12:0]};
          end else if (!a[23] && a[22]) begin
            sel_nxt  = BASE_SRAM;
            offs_nxt = {5'd0, a[17:0]};
          end else if (a[15]) begin
            sel_nxt  = BASE_ZERO;
            offs_nxt = {2'd0, a[21:16], a[14:0]};
          end else if (a[14:13] == 2'b11) begin
            sel_nxt  = BASE_SRAM;
            offs_nxt = {10'd0, a[12:0]};
          end else if (a[14:13] == 2'b00) begin
            sel_nxt  = BASE_WRAM;
            offs_nxt = {10'd0, a[12:0]};
          end else begin
            sel_nxt  = BASE_ZERO;
            offs_nxt = '0;
          end
        end
        MODE_UNKNOWN: begin
          sel_nxt  = BASE_ZERO;
          offs_nxt = {5'd0, a[17:0]};
        end
        default: begin
          sel_nxt  = BASE_ZERO;
          offs_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      sel1_r  <= sel_nxt;
      offs1_r <= offs_nxt;
    end
  end

  // Stage 2: add region base
  assign addr2_nxt = base_value(sel1_r) + {{(DevAddrW-OffsW){1'b0}}, offs1_r};

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      addr2_r <= addr2_nxt;
    end
  end

  // Stage 3: flag ROM results and hold for the consumer
  assign rom_nxt = (addr2_r < SramBase);

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      addr3_r <= addr2_r;
      rom3_r  <= rom_nxt;
    end
  end

  assign out_tvalid   = v3_r;
  assign out_tdata    = {{(32-DevAddrW){1'b0}}, addr3_r};
  assign out_tuser[0] = rom3_r;

  // A stalled input means all three stages are full
  a_full_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v1_r && v2_r && v3_r))
    else $error("input stalled with an empty stage");

  // The ROM flag agrees with the delivered address
  a_rom_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] == (addr3_r < SramBase)))
    else $error("ROM flag does not match address");

  // No translation exceeds the top of ExLoROM save RAM
  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (addr3_r <= MaxDevAddr))
    else $error("device address out of range");

  // An accepted transaction occupies the first stage next cycle
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v1_r)
    else $error("accepted transaction lost at entry");

  // A held middle stage keeps its address
  a_hold_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy3) |=> (v2_r && $stable(addr2_r)))
    else $error("middle stage changed under stall");

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the cartridge bus address mapper
// Drives bus addresses into the input stream under every cartridge map code,
// predicts each device address and ROM flag in the bench, and compares every
// result transaction in order. Both stream sides idle at random in phases.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cbam_pkg::*;

  // Map codes that the block accepts but does not decode
  localparam logic [2:0] ModeSpare6 = 3'd6;
  localparam logic [2:0] ModeSpare7 = 3'd7;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 4;

  typedef struct packed {
    logic [24:0] dev_addr;
    logic        is_rom;
  } mapped_addr_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_data = 3'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = 24'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;

  mapped_addr_t pending_map[$];
  logic [2:0]   active_mode = MODE_UNKNOWN;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           fail_count = 0;
  int unsigned  cycle_count = 0;

  cartridge_bus_address_mapper i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Translate one bus address under the given cartridge map
  function automatic logic [24:0] translate_bus_address(input logic [2:0] mode,
                                                        input logic [23:0] bus);
    logic [31:0] a;
    logic [31:0] bank;
    logic [31:0] off;
    logic [31:0] r;
    a = 32'(bus);
    bank = a >> 16;
    off = a & 32'hFFFF;
    r = 32'd0;
    if (bank == 32'h7E || bank == 32'h7F) begin
      r = WramBase + (a & 32'h1FFFF);
    end else begin
      case (mode)
        MODE_LOROM: begin
          if (a >= 32'h80_0000) a = a - 32'h80_0000;
          bank = a >> 16;
          off = a & 32'hFFFF;
          if (bank >= 32'h70 && off < 32'h8000)
            r = SramBase + (bank - 32'h70) * 32'h8000 + off;
          else if (off < 32'h2000) r = WramBase + (a & 32'h1FFF);
          else if (off < 32'h8000) r = 32'd0;
          else r = ((a & 32'h7F_0000) >> 1) + (a & 32'h7FFF);
        end
        MODE_HIROM: begin
          if (a >= 32'h80_0000) a = a - 32'h80_0000;
          bank = a >> 16;
          off = a & 32'hFFFF;
          if (bank >= 32'h20 && bank <= 32'h3F && off >= 32'h6000 && off <= 32'h7FFF)
            r = SramBase + (bank - 32'h20) * 32'h2000 + off - 32'h6000;
          else if (a <= 32'h3F_FFFF && off < 32'h2000) r = WramBase + (a & 32'h1FFF);
          else r = a & 32'h3F_FFFF;
        end
        MODE_EXLOROM: begin
          // save RAM offset is taken from bank 0x70 on purpose
          if (bank >= 32'hF0 && off < 32'h8000)
            r = SramBase + (bank - 32'h70) * 32'h8000 + off;
          else if (off < 32'h2000) r = WramBase + (a & 32'h1FFF);
          else if (off < 32'h8000) r = 32'd0;
          else if (a[23]) r = ((a & 32'h7F_0000) >> 1) + (a & 32'h7FFF);
          else r = XromBase + ((a & 32'h7F_0000) >> 1) + (a & 32'h7FFF);
        end
        MODE_EXHIROM: begin
          if (a >= 32'hC0_0000) r = a & 32'h3F_FFFF;
          else if (a >= 32'h80_0000 && a[15]) r = a & 32'h3F_7FFF;
          else if (a >= 32'h40_0000 && a < 32'h7E_0000) r = XromBase + (a & 32'h3F_FFFF);
          else if (a <= 32'h3F_FFFF && a[15]) r = XromBase + (a & 32'h3F_7FFF);
          else if (a >= 32'hA0_0000 && a <= 32'hBF_FFFF && (a & 32'h7FFF) >= 32'h6000)
            r = SramBase + (bank - 32'hA0) * 32'h2000 + off - 32'h6000;
          else if (off < 32'h2000) r = WramBase + (a & 32'h1FFF);
          else r = 32'd0;
        end
        MODE_SA1: begin
          if (a >= 32'hC0_0000) begin
            r = a & 32'h3F_FFFF;
          end else if (a >= 32'h80_0000) begin
            if (off >= 32'h8000) r = ((bank - 32'h40) << 15) | (off & 32'h7FFF);
            else if (off >= 32'h6000) r = SramBase + (off - 32'h6000);
            else if (off < 32'h2000) r = WramBase + off;
            else r = 32'd0;
          end else if (a >= 32'h50_0000) begin
            r = 32'd0;
          end else if (a >= 32'h44_0000) begin
            r = SramBase + (a & 32'h1FFF);
          end else if (a >= 32'h40_0000) begin
            r = SramBase + (a - 32'h40_0000);
          end else begin
            if (off >= 32'h8000) r = (bank << 15) + (off & 32'h7FFF);
            else if (off >= 32'h6000) r = SramBase + (off - 32'h6000);
            else if (off < 32'h2000) r = WramBase + off;
            else r = 32'd0;
          end
        end
        MODE_UNKNOWN: r = a & 32'h3_FFFF;
        default: r = 32'd0;
      endcase
    end
    return r[24:0];
  endfunction

  // Pick a bus address, leaning toward bank and offset boundaries
  function automatic logic [23:0] pick_bus_address();
    logic [7:0]  bank;
    logic [15:0] off;
    bank = 8'($urandom_range(255));
    off = 16'($urandom_range(16'hFFFF));
    if ($urandom_range(1) == 0) begin
      case ($urandom_range(21))
        0:  bank = 8'h00;
        1:  bank = 8'h1F;
        2:  bank = 8'h20;
        3:  bank = 8'h3F;
        4:  bank = 8'h40;
        5:  bank = 8'h43;
        6:  bank = 8'h44;
        7:  bank = 8'h4F;
        8:  bank = 8'h50;
        9:  bank = 8'h6F;
        10: bank = 8'h70;
        11: bank = 8'h7D;
        12: bank = 8'h7E;
        13: bank = 8'h7F;
        14: bank = 8'h80;
        15: bank = 8'h9F;
        16: bank = 8'hA0;
        17: bank = 8'hBF;
        18: bank = 8'hC0;
        19: bank = 8'hEF;
        20: bank = 8'hF0;
        default: bank = 8'hFF;
      endcase
    end
    if ($urandom_range(1) == 0) begin
      case ($urandom_range(3))
        0: off = 16'h0000;
        1: off = 16'h2000;
        2: off = 16'h6000;
        default: off = 16'h8000;
      endcase
      if ($urandom_range(1) == 0) off = off - 16'd1;
    end
    return {bank, off};
  endfunction

  // Send one bus address and record the translation it must produce
  task automatic send_bus_address(input logic [23:0] bus);
    mapped_addr_t exp;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= bus;
    do @(posedge clk); while (!in_tready);
    exp.dev_addr = translate_bus_address(active_mode, bus);
    exp.is_rom   = (exp.dev_addr < SramBase);
    pending_map.insert(pending_map.size(), exp);
  endtask

  // Hold the input until every pending translation has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_map.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Write the cartridge map register; call only with the pipeline empty
  task automatic write_map_mode(input logic [2:0] mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    active_mode = mode;
  endtask

  // Check each result transaction against the oldest pending translation
  always @(posedge clk) begin : check_results
    mapped_addr_t exp;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_map.size() == 0) begin
        $display("%0t: unexpected result tdata=%h tuser=%b", $time, out_tdata, out_tuser);
        fail_count++;
      end else begin
        exp = pending_map.pop_front();
        if (out_tdata !== {7'd0, exp.dev_addr}) begin
          $display("%0t: device_address expected %h actual %h",
                   $time, {7'd0, exp.dev_addr}, out_tdata);
          fail_count++;
        end
        if (out_tuser[0] !== exp.is_rom) begin
          $display("%0t: result_is_rom expected %b actual %b",
                   $time, exp.is_rom, out_tuser[0]);
          fail_count++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Unknown map is active out of reset: low 18 bits pass through outside banks 0x7E-0x7F
  task automatic test_reset_default();
    send_bus_address(24'hFFFFFF);
    send_bus_address(24'h7F0001);
    send_bus_address(24'h03FFFF);
    drain_results();
  endtask

  // Region boundaries and special cases of every map code
  task automatic test_region_boundaries();
    write_map_mode(MODE_UNKNOWN);
    send_bus_address(24'h000000);
    send_bus_address(24'h7E1234);
    drain_results();
    write_map_mode(MODE_LOROM);
    send_bus_address(24'hF07FFF);
    send_bus_address(24'h801FFF);
    send_bus_address(24'h006000);
    drain_results();
    write_map_mode(MODE_HIROM);
    send_bus_address(24'h206000);
    send_bus_address(24'hBF7FFF);
    send_bus_address(24'hC00000);
    drain_results();
    // save RAM above the 24-bit range
    write_map_mode(MODE_EXLOROM);
    send_bus_address(24'hF00000);
    send_bus_address(24'hFF7FFF);
    send_bus_address(24'h008000);
    drain_results();
    // upper ROM banks 0x40-0x7D
    write_map_mode(MODE_EXHIROM);
    send_bus_address(24'h400000);
    send_bus_address(24'h7DFFFF);
    send_bus_address(24'hA06000);
    drain_results();
    write_map_mode(MODE_SA1);
    send_bus_address(24'h400000);
    send_bus_address(24'h440000);
    send_bus_address(24'h500000);
    drain_results();
    // undecoded codes map everything outside work RAM to zero
    write_map_mode(ModeSpare6);
    send_bus_address(24'h123456);
    send_bus_address(24'h7FFFFF);
    drain_results();
    write_map_mode(ModeSpare7);
    send_bus_address(24'hFFFFFF);
    drain_results();
  endtask

  // Random addresses in runs under random map codes
  task automatic test_random_mapping(input int n_items, input int s_pct, input int r_pct);
    int sent;
    int run_len;
    sent = 0;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (sent < n_items) begin
      write_map_mode(3'($urandom_range(7)));
      run_len = $urandom_range(20, 60);
      repeat (run_len) begin
        send_bus_address(pick_bus_address());
        sent++;
      end
      drain_results();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 14;
    recv_idle_pct = 69;
    test_reset_default();
    test_region_boundaries();
    test_random_mapping(350, 14, 69);
    test_random_mapping(350, 69, 14);
    test_random_mapping(350, 0, 0);
    drain_results();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule

@@ sim.f @@
sv/cbam_pkg.sv
sv/cartridge_bus_address_mapper.sv
tb/tb_top.sv
